// ----- hw/rtl/filtered_checker_texture_blend_assert.svh -----
// Assertion macros used by the checkerboard texture blend stage.
`ifndef FILTERED_CHECKER_TEXTURE_BLEND_ASSERT_SVH
`define FILTERED_CHECKER_TEXTURE_BLEND_ASSERT_SVH
// Same-cycle implication, sampled on clk_i and disabled during reset.
`define FCTB_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("fctb assertion failed");
// Next-cycle implication, sampled on clk_i and disabled during reset.
`define FCTB_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("fctb assertion failed");
`endif

// ----- hw/rtl/fctb_pkg.sv -----
// Types and constants of the filtered checkerboard texture pipeline.
package fctb_pkg;
  localparam int FRAC_BITS = 16;
  localparam int QW = FRAC_BITS + 1;
  localparam int DW = FRAC_BITS + 2;
  localparam int NW = DW + FRAC_BITS + 1;
  localparam int CW = 34;
  localparam logic [16:0] ONE_W = 17'd65536;
  localparam logic [16:0] HALF_W = 17'd32768;

  typedef struct packed {
    logic signed [31:0] s_coord;
    logic signed [31:0] t_coord;
    logic signed [31:0] ds_dx;
    logic signed [31:0] dt_dx;
    logic signed [31:0] ds_dy;
    logic signed [31:0] dt_dy;
    logic [15:0]        value_one;
    logic [15:0]        value_two;
  } in_t;

  typedef struct packed {
    logic [15:0] blended_value;
    logic [16:0] odd_weight;
  } out_t;

  typedef struct packed {
    logic        point;
    logic        wide;
    logic        odd;
    logic        zero_s;
    logic        zero_t;
    logic        par_s;
    logic        par_t;
    logic [15:0] value_one;
    logic [15:0] value_two;
  } side_t;
endpackage

// ----- hw/rtl/fctb_prep.sv -----
// Front end: filter widths, box tests and divider operands for both axes.
module fctb_prep (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  fctb_pkg::in_t               data_i,
  input  logic                        mode_i,
  output logic                        valid_o,
  output fctb_pkg::side_t             side_o,
  output logic [fctb_pkg::NW-1:0]     num_s_o,
  output logic [fctb_pkg::NW-1:0]     num_t_o,
  output logic [fctb_pkg::DW-1:0]     den_s_o,
  output logic [fctb_pkg::DW-1:0]     den_t_o
);
  import fctb_pkg::*;

  function automatic logic [32:0] mag(input logic [31:0] x);
    logic [32:0] e;
    e = {x[31], x};
    return x[31] ? (~e + 33'd1) : e;
  endfunction

  function automatic logic [DW-1:0] bump_diff(input logic [CW-1:0] p, input logic [CW-1:0] m);
    logic signed [17:0] hi;
    logic [35:0] acc;
    hi = $signed({p[CW-1], p[CW-1:FRAC_BITS+1]}) - $signed({m[CW-1], m[CW-1:FRAC_BITS+1]});
    acc = {{2{hi[17]}}, hi, {FRAC_BITS{1'b0}}};
    if (p[FRAC_BITS]) acc = acc + 36'(p[FRAC_BITS-1:0]);
    if (m[FRAC_BITS]) acc = acc - 36'(m[FRAC_BITS-1:0]);
    return acc[DW-1:0];
  endfunction

  logic [32:0] ds, dt;
  logic [CW-1:0] sp, sm, tp, tm;

  logic [CW-1:0] sp_q, sm_q, tp_q, tm_q;
  logic [QW-1:0] ds_q, dt_q;
  logic zs_q, zt_q, wide_q, odd_q, ps_q, pt_q, mode_q, vld1_q;
  logic [15:0] v1_q, v2_q;

  logic in_check;
  logic [DW-1:0] bs, bt;

  always_comb begin
    logic [32:0] a0, a1, b0, b1;
    a0 = mag(data_i.ds_dx);
    a1 = mag(data_i.ds_dy);
    b0 = mag(data_i.dt_dx);
    b1 = mag(data_i.dt_dy);
    ds = (a0 > a1) ? a0 : a1;
    dt = (b0 > b1) ? b0 : b1;
    sp = {{2{data_i.s_coord[31]}}, data_i.s_coord} + {1'b0, ds};
    sm = {{2{data_i.s_coord[31]}}, data_i.s_coord} - {1'b0, ds};
    tp = {{2{data_i.t_coord[31]}}, data_i.t_coord} + {1'b0, dt};
    tm = {{2{data_i.t_coord[31]}}, data_i.t_coord} - {1'b0, dt};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sp_q   <= sp;
      sm_q   <= sm;
      tp_q   <= tp;
      tm_q   <= tm;
      ds_q   <= ds[QW-1:0];
      dt_q   <= dt[QW-1:0];
      zs_q   <= (ds == '0);
      zt_q   <= (dt == '0);
      wide_q <= (ds > 33'(ONE_W)) || (dt > 33'(ONE_W));
      odd_q  <= data_i.s_coord[FRAC_BITS] ^ data_i.t_coord[FRAC_BITS];
      ps_q   <= data_i.s_coord[FRAC_BITS];
      pt_q   <= data_i.t_coord[FRAC_BITS];
      mode_q <= mode_i;
      v1_q   <= data_i.value_one;
      v2_q   <= data_i.value_two;
    end
  end

  assign in_check = (sp_q[CW-1:FRAC_BITS] == sm_q[CW-1:FRAC_BITS]) &&
                    (tp_q[CW-1:FRAC_BITS] == tm_q[CW-1:FRAC_BITS]);
  assign bs = bump_diff(sp_q, sm_q);
  assign bt = bump_diff(tp_q, tm_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_o.point     <= !mode_q || in_check;
      side_o.wide      <= wide_q;
      side_o.odd       <= odd_q;
      side_o.zero_s    <= zs_q;
      side_o.zero_t    <= zt_q;
      side_o.par_s     <= ps_q;
      side_o.par_t     <= pt_q;
      side_o.value_one <= v1_q;
      side_o.value_two <= v2_q;
      num_s_o <= {1'b0, bs, {FRAC_BITS{1'b0}}} + NW'(ds_q);
      num_t_o <= {1'b0, bt, {FRAC_BITS{1'b0}}} + NW'(dt_q);
      den_s_o <= {ds_q, 1'b0};
      den_t_o <= {dt_q, 1'b0};
    end
  end
endmodule

// ----- hw/rtl/fctb_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
module fctb_div (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [fctb_pkg::NW-1:0] num_i,
  input  logic [fctb_pkg::DW-1:0] den_i,
  output logic [fctb_pkg::QW-1:0] quo_o
);
  import fctb_pkg::*;

  logic [NW-1:0] rem_q [QW-1];
  logic [DW-1:0] den_q [QW-1];
  logic [QW-1:0] quo_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [NW-1:0] rin, trial;
    logic [DW-1:0] din;
    logic [QW-1:0] qin;
    logic          ge;
    if (k == 0) begin : g_first
      assign rin = num_i;
      assign din = den_i;
      assign qin = '0;
    end else begin : g_next
      assign rin = rem_q[k-1];
      assign din = den_q[k-1];
      assign qin = quo_q[k-1];
    end
    assign trial = NW'(din) << (QW - 1 - k);
    assign ge    = rin >= trial;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[k] <= {qin[QW-2:0], ge};
      end
    end
    if (k < QW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= ge ? (rin - trial) : rin;
          den_q[k] <= din;
        end
      end
    end
  end

  assign quo_o = quo_q[QW-1];
endmodule

// ----- hw/rtl/fctb_blend.sv -----
// Back end: axis fractions, odd area, weight selection and value blend.
`include "filtered_checker_texture_blend_assert.svh"
module fctb_blend (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  fctb_pkg::side_t         side_i,
  input  logic [fctb_pkg::QW-1:0] quo_s_i,
  input  logic [fctb_pkg::QW-1:0] quo_t_i,
  output logic                    valid_o,
  output fctb_pkg::out_t          data_o
);
  import fctb_pkg::*;

  function automatic logic [16:0] frac(input logic zero, input logic par,
                                       input logic [QW-1:0] q);
    logic [16:0] r;
    r = (17'(q) > ONE_W) ? ONE_W : 17'(q);
    if (zero) r = par ? ONE_W : 17'd0;
    return r;
  endfunction

  side_t side1_q, side2_q, side3_q;
  logic vld1_q, vld2_q, vld3_q, vld4_q;
  logic [16:0] si1_q, ti1_q, si2_q, ti2_q, w3_q, w4_q;
  logic [33:0] prod2_q;
  logic [32:0] p1_q, p2_q;
  logic [16:0] w_d;
  logic [33:0] sum;

  always_comb begin
    logic [18:0] rnd;
    logic signed [19:0] a;
    rnd = 19'((prod2_q + 34'd16384) >> 15);
    a = $signed({3'b0, si2_q}) + $signed({3'b0, ti2_q}) - $signed({1'b0, rnd});
    if (side2_q.point) begin
      w_d = side2_q.odd ? ONE_W : 17'd0;
    end else if (side2_q.wide) begin
      w_d = HALF_W;
    end else if (a < 0) begin
      w_d = 17'd0;
    end else if (a > $signed(20'(ONE_W))) begin
      w_d = ONE_W;
    end else begin
      w_d = a[16:0];
    end
  end

  assign sum = 34'(p1_q) + 34'(p2_q) + 34'd32768;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q  <= 1'b0;
      vld2_q  <= 1'b0;
      vld3_q  <= 1'b0;
      vld4_q  <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      vld1_q  <= valid_i;
      vld2_q  <= vld1_q;
      vld3_q  <= vld2_q;
      vld4_q  <= vld3_q;
      valid_o <= vld4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side1_q <= side_i;
      si1_q   <= frac(side_i.zero_s, side_i.par_s, quo_s_i);
      ti1_q   <= frac(side_i.zero_t, side_i.par_t, quo_t_i);
      side2_q <= side1_q;
      si2_q   <= si1_q;
      ti2_q   <= ti1_q;
      prod2_q <= si1_q * ti1_q;
      side3_q <= side2_q;
      w3_q    <= w_d;
      p1_q    <= (ONE_W - w3_q) * side3_q.value_one;
      p2_q    <= w3_q * side3_q.value_two;
      w4_q    <= w3_q;
      data_o.blended_value <= sum[31:16];
      data_o.odd_weight    <= w4_q;
    end
  end

  `FCTB_ASSERT_IMP(a_weight_range, vld3_q, w3_q <= ONE_W)
  `FCTB_ASSERT_IMP(a_point_weight, vld3_q && side3_q.point, (w3_q == '0) || (w3_q == ONE_W))
  `FCTB_ASSERT_NXT(a_stall_hold, !en_i, valid_o && $stable(data_o))
endmodule

// ----- hw/rtl/filtered_checker_texture_blend.sv -----
// Top level of the box-filtered checkerboard texture pipeline.
// Throughput is one transaction per cycle while the output is not stalled; the 17-stage divider sets the depth.
// A stalled valid output freezes the whole pipeline and input stall rises with it.
// Reset clears all valid bits and sets mode_q to the box filter.
module filtered_checker_texture_blend (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  fctb_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output fctb_pkg::out_t  out_data_o,
  input  logic            cfg_we_i,
  input  logic            cfg_data_i
);
  import fctb_pkg::*;

  logic en, mode_q, prep_vld;
  side_t prep_side;
  logic [NW-1:0] num_s, num_t;
  logic [DW-1:0] den_s, den_t;
  logic [QW-1:0] quo_s, quo_t;
  side_t side_q [QW];
  logic [QW-1:0] vld_q;

  assign en = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
    end else if (cfg_we_i) begin
      mode_q <= cfg_data_i;
    end
  end

  fctb_prep u_prep (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i), .data_i(in_data_i), .mode_i(mode_q),
    .valid_o(prep_vld), .side_o(prep_side), .num_s_o(num_s), .num_t_o(num_t),
    .den_s_o(den_s), .den_t_o(den_t)
  );

  fctb_div u_div_s (.clk_i, .en_i(en), .num_i(num_s), .den_i(den_s), .quo_o(quo_s));
  fctb_div u_div_t (.clk_i, .en_i(en), .num_i(num_t), .den_i(den_t), .quo_o(quo_t));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[QW-2:0], prep_vld};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= prep_side;
      for (int k = 1; k < QW; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  fctb_blend u_blend (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vld_q[QW-1]), .side_i(side_q[QW-1]),
    .quo_s_i(quo_s), .quo_t_i(quo_t), .valid_o(out_valid_o), .data_o(out_data_o)
  );
endmodule

// ----- tb/filtered_checker_texture_blend_test.sv -----
// Self-checking testbench for the box-filtered checkerboard texture pipeline.
module filtered_checker_texture_blend_test;
  timeunit 1ns;
  timeprecision 1ps;
  import fctb_pkg::*;

  localparam int LATENCY = 24;
  localparam int RANDOM_ITEMS = 2000;
  localparam logic MODE_POINT = 1'b0;
  localparam logic MODE_BOX = 1'b1;
  localparam longint BIAS = 64'sd1 << 40;

  typedef struct {
    logic          mode;
    logic   [31:0] s;
    logic   [31:0] t;
    logic   [31:0] dsx;
    logic   [31:0] dtx;
    logic   [31:0] dsy;
    logic   [31:0] dty;
    logic   [15:0] v1;
    logic   [15:0] v2;
    bit            known;
    logic   [16:0] w;
  } row_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;
  logic cfg_we_i;
  logic cfg_data_i;

  logic mode_shadow;
  out_t pending_texels[$];
  int mismatches;
  bit quiet_tail;
  bit hold_request;
  row_t rows[$];

  filtered_checker_texture_blend u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i), .cfg_data_i(cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic longint floor_q(longint x, int k);
    return longint'(unsigned'(x + BIAS) >> k) - (BIAS >>> k);
  endfunction

  function automatic longint bump_area(longint x);
    longint q;
    longint f;
    q = floor_q(x, FRAC_BITS + 1);
    f = (x + BIAS) & ((64'sd1 << (FRAC_BITS + 1)) - 1);
    f = f - (64'sd1 << FRAC_BITS);
    if (f < 0) f = 0;
    return q * (64'sd1 << FRAC_BITS) + f;
  endfunction

  function automatic longint odd_span(longint c, longint d);
    longint unsigned num;
    longint r;
    if (d == 0) return (floor_q(c, FRAC_BITS) & 1) ? 65536 : 0;
    num = longint'(bump_area(c + d) - bump_area(c - d));
    r = longint'(((num << 16) + d) / (2 * d));
    return r > 65536 ? 65536 : r;
  endfunction

  function automatic out_t shade_texel(logic mode, in_t x);
    longint s;
    longint t;
    longint ds;
    longint dt;
    longint a;
    longint b;
    longint w;
    longint si;
    longint ti;
    out_t o;
    s = longint'(x.s_coord);
    t = longint'(x.t_coord);
    w = ((floor_q(s, FRAC_BITS) + floor_q(t, FRAC_BITS)) & 1) ? 65536 : 0;
    if (mode == MODE_BOX) begin
      a = longint'(x.ds_dx); a = a < 0 ? -a : a;
      b = longint'(x.ds_dy); b = b < 0 ? -b : b;
      ds = a > b ? a : b;
      a = longint'(x.dt_dx); a = a < 0 ? -a : a;
      b = longint'(x.dt_dy); b = b < 0 ? -b : b;
      dt = a > b ? a : b;
      if (!(floor_q(s - ds, FRAC_BITS) == floor_q(s + ds, FRAC_BITS) &&
            floor_q(t - dt, FRAC_BITS) == floor_q(t + dt, FRAC_BITS))) begin
        if (ds > 65536 || dt > 65536) begin
          w = 32768;
        end else begin
          si = odd_span(s, ds);
          ti = odd_span(t, dt);
          a = si + ti - ((2 * si * ti + 32768) >>> 16);
          if (a < 0) a = 0;
          if (a > 65536) a = 65536;
          w = a;
        end
      end
    end
    o.odd_weight = w[16:0];
    o.blended_value = 16'((((65536 - w) * x.value_one) + w * x.value_two + 32768) >>> 16);
    return o;
  endfunction

  function automatic logic [15:0] mix(logic [16:0] w, logic [15:0] a, logic [15:0] b);
    longint r;
    r = ((65536 - longint'(w)) * a + longint'(w) * b + 32768) >>> 16;
    return r[15:0];
  endfunction

  function automatic logic [31:0] rand_deriv();
    case ($urandom_range(0, 5))
      0: return 32'($urandom_range(0, 65536)) * ($urandom_range(0, 1) ? 1 : -1);
      1: return 32'($urandom_range(0, 4096)) * ($urandom_range(0, 1) ? 1 : -1);
      2: return 32'h0;
      3: return $urandom();
      default: return 32'($urandom_range(0, 70000)) * ($urandom_range(0, 1) ? 1 : -1);
    endcase
  endfunction

  function automatic logic [31:0] rand_coord();
    if ($urandom_range(0, 3) == 0) return $urandom();
    return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
  endfunction

  task automatic write_mode(logic m);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mode_shadow = m;
  endtask

  task automatic drain();
    while (pending_texels.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic send_texel(in_t x, bit allow_gaps);
    if (allow_gaps && !quiet_tail && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= x;
    do @(posedge clk_i); while (in_stall_o);
    pending_texels.push_back(shade_texel(mode_shadow, x));
  endtask

  task automatic add_row(logic m, logic [31:0] s, logic [31:0] t, logic [31:0] dsx,
                         logic [31:0] dtx, logic [31:0] dsy, logic [31:0] dty,
                         logic [15:0] v1, logic [15:0] v2, bit known, logic [16:0] w);
    row_t r;
    r = '{m, s, t, dsx, dtx, dsy, dty, v1, v2, known, w};
    rows.push_back(r);
  endtask

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_texels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data_o);
      end else begin
        want = pending_texels.pop_front();
        if (want.blended_value !== out_data_o.blended_value ||
            want.odd_weight !== out_data_o.odd_weight) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected value %h weight %h, got value %h weight %h",
                     want.blended_value, want.odd_weight,
                     out_data_o.blended_value, out_data_o.odd_weight);
        end
      end
    end
  end

  initial begin
    int gap;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        out_stall_i <= 1'b1;
        repeat (80) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_request = 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 6);
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    in_t x;
    row_t r;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_we_i = 1'b0;
    cfg_data_i = 1'b0;
    mode_shadow = MODE_BOX;
    mismatches = 0;
    quiet_tail = 1'b0;
    hold_request = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Box mode after reset, filter inside one check, then wide filters and partly covered footprints.
    add_row(MODE_BOX, 32'h0000_8000, 32'h0000_8000, 32'h100, 32'h100, 0, 0,
            16'hFFFF, 16'h0000, 1, 17'd0);
    add_row(MODE_BOX, 32'h0001_8000, 32'h0000_8000, 32'h100, 0, 0, 32'h100,
            16'h1234, 16'hABCD, 1, 17'd65536);
    add_row(MODE_BOX, 32'h0000_8000, 32'h0000_8000, 32'h8000_0000, 0, 0, 0,
            16'hFFFF, 16'h0000, 1, 17'd32768);
    add_row(MODE_BOX, 32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h8000_0000, 32'h7FFF_FFFF,
            32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF, 1, 17'd32768);
    add_row(MODE_BOX, 32'h0000_0000, 32'h0000_8000, 32'h0001_0000, 0, 0, 0,
            16'h0000, 16'hFFFF, 0, 0);
    add_row(MODE_BOX, 32'h0000_0000, 32'h0000_0000, 32'h0000_8000, 32'h0000_8000,
            32'hFFFF_0000, 32'hFFFF_8000, 16'h8000, 16'h7FFF, 0, 0);
    add_row(MODE_BOX, 32'h0000_0000, 32'h0001_8000, 32'h0000_4000, 0, 0, 0,
            16'h0000, 16'hFFFF, 0, 0);
    add_row(MODE_BOX, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF,
            32'h0001_0000, 32'hFFFF_0000, 16'h5555, 16'hAAAA, 0, 0);
    add_row(MODE_BOX, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0010, 32'h0000_0010,
            0, 0, 16'hFFFF, 16'h0001, 0, 0);
    // Point mode ignores derivatives; the last row returns to box mode.
    add_row(MODE_POINT, 32'h0000_8000, 32'h0000_8000, 32'h8000_0000, 32'h8000_0000,
            32'h8000_0000, 32'h8000_0000, 16'hFFFF, 16'h0000, 1, 17'd0);
    add_row(MODE_POINT, 32'hFFFF_8000, 32'h0000_8000, 32'h7FFF_FFFF, 0, 0, 0,
            16'h0000, 16'hFFFF, 1, 17'd65536);
    add_row(MODE_POINT, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0,
            16'hFFFF, 16'h0000, 1, 17'd0);
    add_row(MODE_POINT, 32'h7FFF_FFFF, 32'h0000_0000, 0, 0, 0, 0,
            16'h0000, 16'hFFFF, 1, 17'd65536);
    add_row(MODE_BOX, 32'h0000_C000, 32'h0000_C000, 32'h0000_8000, 32'h0000_8000,
            0, 0, 16'h0000, 16'hFFFF, 0, 0);

    foreach (rows[i]) begin
      r = rows[i];
      if (r.mode !== mode_shadow) begin
        in_valid_i <= 1'b0;
        drain();
        write_mode(r.mode);
      end
      x = '{r.s, r.t, r.dsx, r.dtx, r.dsy, r.dty, r.v1, r.v2};
      send_texel(x, 1'b0);
      if (r.known) begin
        pending_texels[$].odd_weight = r.w;
        pending_texels[$].blended_value = mix(r.w, r.v1, r.v2);
      end
    end
    in_valid_i <= 1'b0;
    drain();
    write_mode(MODE_BOX);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 300) hold_request = 1'b1;
      if (n == RANDOM_ITEMS - 200) quiet_tail = 1'b1;
      if (n % 500 == 499) begin
        in_valid_i <= 1'b0;
        drain();
        write_mode(mode_shadow == MODE_BOX ? MODE_POINT : MODE_BOX);
      end
      x.s_coord = rand_coord();
      x.t_coord = rand_coord();
      x.ds_dx = rand_deriv();
      x.dt_dx = rand_deriv();
      x.ds_dy = rand_deriv();
      x.dt_dy = rand_deriv();
      x.value_one = 16'($urandom());
      x.value_two = 16'($urandom());
      send_texel(x, 1'b1);
    end
    in_valid_i <= 1'b0;

    fork
      begin
        while (pending_texels.size() != 0) @(posedge clk_i);
        repeat (LATENCY + 8) @(posedge clk_i);
      end
      begin
        repeat (20000) @(posedge clk_i);
        mismatches++;
      end
    join_any
    disable fork;
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
